>>> rtl/sgdm_pkg.sv
// ----------------------------------------------------------------------------
// sgdm_pkg
// Shared widths, register codes, control structs and fixed-point helpers for
// the SGD momentum update block.
// ----------------------------------------------------------------------------
package sgdm_pkg;

  localparam int unsigned IDX_W             = 12;
  localparam int unsigned DATA_W            = 32;
  localparam int unsigned RATE_W            = 16;
  localparam int unsigned FRAC_W            = 16;
  localparam int unsigned CFG_IDX_W         = 2;
  localparam int unsigned SGDM_MAX_ELEMENTS = 4096;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LEARNING_RATE = 2'd0,
    REG_MOMENTUM      = 2'd1,
    REG_DECAY         = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [RATE_W-1:0] learning_rate;
    logic [RATE_W-1:0] momentum_factor;
    logic [RATE_W-1:0] decay_factor;
  } rates_t;

  typedef struct packed {
    logic              en;
    logic [IDX_W-1:0]  idx;
  } vel_rd_t;

  typedef struct packed {
    logic              en;
    logic [IDX_W-1:0]  idx;
    logic [DATA_W-1:0] data;
  } vel_wr_t;

  // Unsigned Q0.16 rate times signed Q16.16 value, floored back to Q16.16.
  function automatic logic signed [DATA_W:0] rate_mul(
    input logic        [RATE_W-1:0] rate,
    input logic signed [DATA_W-1:0] val
  );
    logic signed [DATA_W+RATE_W:0] prod;
    prod = $signed({1'b0, rate}) * val;
    return prod[DATA_W+RATE_W:FRAC_W];
  endfunction

  // Clamp a 34-bit signed sum to the signed 32-bit range.
  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [DATA_W+1:0] x);
    logic signed [DATA_W-1:0] r;
    if ((x[DATA_W+1] == x[DATA_W]) && (x[DATA_W] == x[DATA_W-1])) begin
      r = x[DATA_W-1:0];
    end else if (x[DATA_W+1]) begin
      r = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(DATA_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

>>> rtl/sgdm_stream_if.sv
// ----------------------------------------------------------------------------
// sgdm_stream_if
// Valid/ready channels for parameter elements in and updated elements out.
// ----------------------------------------------------------------------------
interface sgdm_in_if;
  logic                                     valid;
  logic                                     ready;
  logic        [sgdm_pkg::IDX_W-1:0]        element_index;
  logic signed [sgdm_pkg::DATA_W-1:0]       param_value;
  logic signed [sgdm_pkg::DATA_W-1:0]       grad_value;
  logic                                     has_grad;

  modport source (output valid, element_index, param_value, grad_value, has_grad,
                  input ready);
  modport sink   (input valid, element_index, param_value, grad_value, has_grad,
                  output ready);
endinterface

interface sgdm_out_if;
  logic                                     valid;
  logic                                     ready;
  logic signed [sgdm_pkg::DATA_W-1:0]       new_param;
  logic signed [sgdm_pkg::DATA_W-1:0]       decayed_grad;

  modport source (output valid, new_param, decayed_grad, input ready);
  modport sink   (input valid, new_param, decayed_grad, output ready);
endinterface

>>> rtl/sgdm_vel_store.sv
// ----------------------------------------------------------------------------
// sgdm_vel_store
// Velocity memory: one write port, one registered read port, and a zeroing
// sweep after reset that holds busy high until every entry is cleared.
// ----------------------------------------------------------------------------
module sgdm_vel_store #(
  parameter int unsigned DEPTH = sgdm_pkg::SGDM_MAX_ELEMENTS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  sgdm_pkg::vel_rd_t             rd,
  output logic [sgdm_pkg::DATA_W-1:0]   rd_data,
  input  sgdm_pkg::vel_wr_t             wr,
  output logic                          busy
);
  import sgdm_pkg::*;

  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [DATA_W-1:0] mem [DEPTH];
  logic [ADDR_W-1:0] clr_addr;
  logic              wen;
  logic [ADDR_W-1:0] waddr;
  logic [DATA_W-1:0] wdata;

  always_comb begin
    wen   = busy | wr.en;
    waddr = busy ? clr_addr : wr.idx[ADDR_W-1:0];
    wdata = busy ? '0 : wr.data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b1;
      clr_addr <= '0;
    end else if (busy) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == ADDR_W'(DEPTH - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wen) begin
      mem[waddr] <= wdata;
    end
    if (rd.en) begin
      rd_data <= mem[rd.idx[ADDR_W-1:0]];
    end
  end

endmodule

>>> rtl/sgdm_pipe.sv
// ----------------------------------------------------------------------------
// sgdm_pipe
// Five-stage update pipeline: decay product, decayed gradient, learning-rate
// product with velocity read, momentum step with write-back, parameter sum.
// ----------------------------------------------------------------------------
module sgdm_pipe #(
  parameter int unsigned MAX_ELEMENTS = sgdm_pkg::SGDM_MAX_ELEMENTS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  sgdm_pkg::rates_t            rates,
  input  logic                        busy,
  sgdm_in_if.sink                     in_stream,
  sgdm_out_if.source                  out_stream,
  output sgdm_pkg::vel_rd_t           rd,
  input  logic [sgdm_pkg::DATA_W-1:0] rd_data,
  output sgdm_pkg::vel_wr_t           wr
);
  import sgdm_pkg::*;

  logic a_v, b_v, c_v, d_v, o_v;
  logic a_rdy, b_rdy, c_rdy, d_rdy, o_rdy;
  logic in_take;

  logic        [IDX_W-1:0]  a_idx, b_idx, c_idx, d_idx;
  logic signed [DATA_W-1:0] a_p, b_p, c_p, d_p;
  logic signed [DATA_W-1:0] a_g;
  logic signed [DATA_W-1:0] b_dg, c_dg, d_dg;
  logic                     a_act, b_act, c_act, d_act;
  logic                     a_instore, b_instore, c_instore;
  logic signed [DATA_W:0]   a_dprod;
  logic signed [DATA_W:0]   c_lrp;
  logic signed [DATA_W-1:0] c_fwd;
  logic                     c_fwd_vld;
  logic signed [DATA_W-1:0] c_vold;
  logic signed [DATA_W-1:0] c_vel;
  logic signed [DATA_W:0]   c_momp;
  logic                     d_hit;
  logic signed [DATA_W-1:0] d_vel;
  logic                     d_wr;
  logic signed [DATA_W-1:0] o_new, o_dg;

  always_comb begin
    o_rdy = !o_v || out_stream.ready;
    d_rdy = !d_v || o_rdy;
    c_rdy = !c_v || d_rdy;
    b_rdy = !b_v || c_rdy;
    a_rdy = !a_v || b_rdy;
    in_stream.ready = a_rdy && !busy;
    in_take = in_stream.valid && in_stream.ready;
  end

  // Stage A: register the beat and the decay product.
  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
    end else if (a_rdy) begin
      a_v <= in_take;
    end
  end

  always_ff @(posedge clk) begin
    if (a_rdy) begin
      a_idx     <= in_stream.element_index;
      a_p       <= in_stream.param_value;
      a_g       <= in_stream.grad_value;
      a_act     <= in_stream.has_grad;
      a_instore <= (32'(in_stream.element_index) < MAX_ELEMENTS);
      a_dprod   <= rate_mul(rates.decay_factor, in_stream.param_value);
    end
  end

  // Stage B: decayed gradient.
  always_ff @(posedge clk) begin
    if (rst) begin
      b_v <= 1'b0;
    end else if (b_rdy) begin
      b_v <= a_v;
    end
  end

  always_ff @(posedge clk) begin
    if (b_rdy) begin
      b_dg      <= sat32({{2{a_g[DATA_W-1]}}, a_g} + {a_dprod[DATA_W], a_dprod});
      b_p       <= a_p;
      b_idx     <= a_idx;
      b_act     <= a_act;
      b_instore <= a_instore;
    end
  end

  // Stage C: learning-rate product; velocity arrives from the store.
  always_comb begin
    rd.en  = c_rdy && b_v;
    rd.idx = b_idx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_v       <= 1'b0;
      c_fwd_vld <= 1'b0;
    end else if (c_rdy) begin
      c_v       <= b_v;
      c_fwd_vld <= 1'b0;
    end else begin
      c_fwd_vld <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (c_rdy) begin
      c_lrp     <= rate_mul(rates.learning_rate, b_dg);
      c_dg      <= b_dg;
      c_p       <= b_p;
      c_idx     <= b_idx;
      c_act     <= b_act;
      c_instore <= b_instore;
    end else begin
      c_fwd     <= c_vold;
    end
  end

  // Forward the velocity of the item ahead when it hits the same entry.
  always_comb begin
    d_hit = d_v && d_wr && (d_idx == c_idx);
    if (!c_instore) begin
      c_vold = '0;
    end else if (d_hit) begin
      c_vold = d_vel;
    end else if (c_fwd_vld) begin
      c_vold = c_fwd;
    end else begin
      c_vold = rd_data;
    end
    c_momp = rate_mul(rates.momentum_factor, c_vold);
    c_vel  = sat32({c_momp[DATA_W], c_momp} - {c_lrp[DATA_W], c_lrp});
    wr.en   = c_v && d_rdy && c_act && c_instore;
    wr.idx  = c_idx;
    wr.data = c_vel;
  end

  // Stage D: new velocity, written back on entry.
  always_ff @(posedge clk) begin
    if (rst) begin
      d_v  <= 1'b0;
      d_wr <= 1'b0;
    end else if (d_rdy) begin
      d_v  <= c_v;
      d_wr <= c_act && c_instore;
    end
  end

  always_ff @(posedge clk) begin
    if (d_rdy) begin
      d_vel <= c_vel;
      d_idx <= c_idx;
      d_p   <= c_p;
      d_dg  <= c_dg;
      d_act <= c_act;
    end
  end

  // Output register: parameter plus velocity for elements with a gradient, else the parameter.
  always_ff @(posedge clk) begin
    if (rst) begin
      o_v <= 1'b0;
    end else if (o_rdy) begin
      o_v <= d_v;
    end
  end

  always_ff @(posedge clk) begin
    if (o_rdy) begin
      o_new <= d_act ? sat32({{2{d_p[DATA_W-1]}}, d_p} + {{2{d_vel[DATA_W-1]}}, d_vel})
                     : d_p;
      o_dg  <= d_act ? d_dg : '0;
    end
  end

  always_comb begin
    out_stream.valid        = o_v;
    out_stream.new_param    = o_new;
    out_stream.decayed_grad = o_dg;
  end

endmodule

>>> rtl/sgd_momentum_update_top.sv
// ----------------------------------------------------------------------------
// sgd_momentum_update_top
// Streaming SGD step with momentum and weight decay on Q16.16 elements.
// One element enters per clock while the store is idle and the output not
// stalled; the rate is set by the momentum step, which reads, updates and
// writes one velocity entry per cycle, with the previous entry forwarded so
// repeated indices stream without gaps. After reset the velocity store of
// min(MAX_ELEMENTS, 4096) entries is zeroed one entry per cycle, and no
// element is taken until it finishes. The user must write rate registers via
// cfg_wr_en/cfg_index/cfg_data only while idle; the block does not check it.
// ----------------------------------------------------------------------------
module sgd_momentum_update_top #(
  parameter int unsigned MAX_ELEMENTS = sgdm_pkg::SGDM_MAX_ELEMENTS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wr_en,
  input  logic [sgdm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sgdm_pkg::RATE_W-1:0]    cfg_data,
  sgdm_in_if.sink                        in_stream,
  sgdm_out_if.source                     out_stream
);
  import sgdm_pkg::*;

  localparam int unsigned STORE_DEPTH =
    (MAX_ELEMENTS < (2 ** IDX_W)) ? MAX_ELEMENTS : (2 ** IDX_W);

  rates_t            rates;
  vel_rd_t           rd;
  vel_wr_t           wr;
  logic [DATA_W-1:0] rd_data;
  logic              busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      rates <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_LEARNING_RATE: rates.learning_rate   <= cfg_data;
        REG_MOMENTUM:      rates.momentum_factor <= cfg_data;
        REG_DECAY:         rates.decay_factor    <= cfg_data;
        default: ;
      endcase
    end
  end

  sgdm_pipe #(
    .MAX_ELEMENTS (MAX_ELEMENTS)
  ) u_pipe (
    .clk        (clk),
    .rst        (rst),
    .rates      (rates),
    .busy       (busy),
    .in_stream  (in_stream),
    .out_stream (out_stream),
    .rd         (rd),
    .rd_data    (rd_data),
    .wr         (wr)
  );

  sgdm_vel_store #(
    .DEPTH (STORE_DEPTH)
  ) u_vel_store (
    .clk     (clk),
    .rst     (rst),
    .rd      (rd),
    .rd_data (rd_data),
    .wr      (wr),
    .busy    (busy)
  );

endmodule

>>> rtl/sgdm_checker.sv
// ----------------------------------------------------------------------------
// sgdm_checker
// Port-level checks for the SGD momentum update block, bound to the top.
// ----------------------------------------------------------------------------
module sgdm_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [sgdm_pkg::DATA_W-1:0]    new_param,
  input logic [sgdm_pkg::DATA_W-1:0]    decayed_grad
);
  import sgdm_pkg::*;

  localparam int unsigned PIPE_DEPTH = 5;

  logic [3:0] inflight;
  logic       in_beat, out_beat;

  assign in_beat  = in_valid && in_ready;
  assign out_beat = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= '0;
    end else if (in_beat && !out_beat) begin
      inflight <= inflight + 1'b1;
    end else if (out_beat && !in_beat) begin
      inflight <= inflight - 1'b1;
    end
  end

  a_no_spurious_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (inflight != '0))
    else $error("result beat without a pending element");

  a_bounded_inflight: assert property (@(posedge clk) disable iff (rst)
    inflight <= 4'(PIPE_DEPTH))
    else $error("more elements in flight than pipeline stages");

  a_clear_after_reset: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !in_ready)
    else $error("element taken before velocity store was cleared");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(new_param) && $stable(decayed_grad)))
    else $error("stalled result beat changed");

endmodule

bind sgd_momentum_update_top sgdm_checker u_sgdm_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_stream.valid),
  .in_ready     (in_stream.ready),
  .out_valid    (out_stream.valid),
  .out_ready    (out_stream.ready),
  .new_param    (out_stream.new_param),
  .decayed_grad (out_stream.decayed_grad)
);
